// ----- rtl/core/slur_pkg.sv -----
// slur_pkg: constants and types shared by the shuffled Lehmer generator
// no dependencies; imported by every module of the block
`default_nettype none

package slur_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 32;
  localparam int unsigned WARMUP_EXTRA      = 8;
  localparam int unsigned VAL_W             = 31;
  localparam int unsigned MULT_W            = 15;
  localparam int unsigned PROD_W            = VAL_W + MULT_W;

  localparam logic [MULT_W-1:0] LCG_MULT    = 15'd16807;
  localparam logic [VAL_W-1:0]  LCG_MOD     = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  CLAMP_LIMIT = 31'd2147483390;

  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_RED   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_WRITE = 6'b100000
  } slur_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/slur_mulmod.sv -----
// slur_mulmod: shared step x <- 16807 * x mod (2^31 - 1), product registered
// then folded next cycle; depends on slur_pkg
`default_nettype none

module slur_mulmod
  import slur_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             load,
  input  wire logic [VAL_W-1:0] x_i,
  output logic      [VAL_W-1:0] y_o
);

  logic [PROD_W-1:0] prod_r;
  logic [VAL_W:0]    fold;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= PROD_W'(x_i) * PROD_W'(LCG_MULT);
    end
  end

  // 2^31 = 1 mod the modulus, so high part folds onto the low part
  always_comb begin
    fold = (VAL_W + 1)'(prod_r[PROD_W-1:VAL_W]) + (VAL_W + 1)'(prod_r[VAL_W-1:0]);
    if (fold >= (VAL_W + 1)'(LCG_MOD)) begin
      y_o = VAL_W'(fold - (VAL_W + 1)'(LCG_MOD));
    end else begin
      y_o = fold[VAL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/slur_slotdiv.sv -----
// slur_slotdiv: slot index from the shuffle output, reciprocal multiply then one
// compare-and-subtract correction, each step registered; depends on slur_pkg
`default_nettype none

module slur_slotdiv
  import slur_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W         = 5
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend_i,
  output logic                  busy_o,
  output logic      [IDX_W-1:0] slot_o
);

  localparam longint unsigned SLOT_DIV = 64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(TABLE_ENTRIES);
  // reciprocal scaled by 2^31; the estimate is low by at most one
  localparam longint unsigned RCP      = (64'd1 << VAL_W) / SLOT_DIV;
  localparam int unsigned     PW       = VAL_W + IDX_W;

  logic [VAL_W-1:0] x_r, x_nxt;
  logic [IDX_W-1:0] est_r, est_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic             busy_r;
  logic [PW-1:0]    scaled;
  logic [PW-1:0]    back;
  logic [PW-1:0]    rem;
  logic [IDX_W:0]   q_up;

  always_comb begin
    x_nxt    = x_r;
    est_nxt  = est_r;
    slot_nxt = slot_r;
    scaled   = PW'(dividend_i) * PW'(RCP);
    back     = PW'(est_r) * PW'(SLOT_DIV);
    rem      = PW'(x_r) - back;
    q_up     = (IDX_W + 1)'(est_r) + (IDX_W + 1)'(rem >= PW'(SLOT_DIV));
    if (start) begin
      x_nxt   = dividend_i;
      est_nxt = scaled[PW-1:VAL_W];
    end
    if (busy_r) begin
      // an index past the table saturates to the last slot
      if (q_up >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
        slot_nxt = IDX_W'(TABLE_ENTRIES - 1);
      end else begin
        slot_nxt = q_up[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    est_r  <= est_nxt;
    slot_r <= slot_nxt;
  end

  assign busy_o = busy_r;
  assign slot_o = slot_r;

endmodule

`default_nettype wire

// ----- rtl/core/slur_table.sv -----
// slur_table: shuffle table memory, one write port and one registered read
// port; depends on slur_pkg
`default_nettype none

module slur_table
  import slur_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int unsigned IDX_W         = 5
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [VAL_W-1:0] wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/core/shuffled_lehmer_uniform_rng.sv -----
// a draw runs the multiply, the fold, the slot divide and the table read, then the
// write; a seeding draw first runs TABLE_ENTRIES + 8 warm-up multiply-fold steps
// one request at a time: a new one is taken only in the idle state, after the
// previous result is written; a stalled result holds off the write
// reset: synchronous, active low; generator state 1, shuffle output 0 so the
// first draw seeds; the table holds nothing until seeding fills it
`default_nettype none

module shuffled_lehmer_uniform_rng
  import slur_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_command,
  input  wire logic [VAL_W-1:0] in_seed,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [VAL_W-1:0] out_sample,
  output logic                  out_clamped
);

  localparam int unsigned IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned SEED_N = TABLE_ENTRIES + WARMUP_EXTRA;
  localparam int unsigned CNT_W  = $clog2(SEED_N + 1);

  slur_state_t      state_r, state_nxt;
  logic [VAL_W-1:0] lehmer_r, lehmer_nxt;
  logic [VAL_W-1:0] shuf_r, shuf_nxt;
  logic             seeding_r, seeding_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_sample_r, out_sample_nxt;
  logic             out_clamped_r, out_clamped_nxt;

  logic [CNT_W-1:0] cnt_m1;
  logic [VAL_W-1:0] step_val;
  logic             mul_load;
  logic             div_start;
  logic             div_busy;
  logic [IDX_W-1:0] slot;
  logic             tbl_we;
  logic [IDX_W-1:0] tbl_waddr;
  logic [VAL_W-1:0] tbl_wdata;
  logic [VAL_W-1:0] tbl_rdata;
  logic             in_fire;
  logic             emit;

  slur_mulmod u_mulmod (
    .clk (clk),
    .load(mul_load),
    .x_i (lehmer_r),
    .y_o (step_val)
  );

  slur_slotdiv #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_slotdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend_i(shuf_r),
    .busy_o    (div_busy),
    .slot_o    (slot)
  );

  slur_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .raddr(slot),
    .rdata(tbl_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign emit     = (state_r == ST_WRITE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt       = state_r;
    lehmer_nxt      = lehmer_r;
    shuf_nxt        = shuf_r;
    seeding_nxt     = seeding_r;
    cnt_nxt         = cnt_r;
    out_sample_nxt  = out_sample_r;
    out_clamped_nxt = out_clamped_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    mul_load        = 1'b0;
    div_start       = 1'b0;
    tbl_we          = 1'b0;
    tbl_waddr       = slot;
    tbl_wdata       = lehmer_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_MUL;
          if (in_command == CMD_RESEED || shuf_r == '0) begin
            // zero seed and a seed equal to the modulus both start from one
            if (in_seed == '0 || in_seed == LCG_MOD) begin
              lehmer_nxt = VAL_W'(1);
            end else begin
              lehmer_nxt = in_seed;
            end
            seeding_nxt = 1'b1;
            cnt_nxt     = CNT_W'(SEED_N);
          end else begin
            seeding_nxt = 1'b0;
          end
        end
      end
      ST_MUL: begin
        mul_load  = 1'b1;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        lehmer_nxt = step_val;
        if (seeding_r) begin
          // warm-up steps; the last ones fill the table from the top slot down
          tbl_we    = (cnt_m1 < CNT_W'(TABLE_ENTRIES));
          tbl_waddr = cnt_m1[IDX_W-1:0];
          tbl_wdata = step_val;
          cnt_nxt   = cnt_m1;
          state_nxt = ST_MUL;
          if (cnt_r == CNT_W'(1)) begin
            seeding_nxt = 1'b0;
            shuf_nxt    = step_val;
          end
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (emit) begin
          tbl_we          = 1'b1;
          shuf_nxt        = tbl_rdata;
          out_sample_nxt  = tbl_rdata;
          out_clamped_nxt = (tbl_rdata >= CLAMP_LIMIT);
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lehmer_r    <= VAL_W'(1);
      shuf_r      <= '0;
      seeding_r   <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lehmer_r    <= lehmer_nxt;
      shuf_r      <= shuf_nxt;
      seeding_r   <= seeding_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r  <= out_sample_nxt;
    out_clamped_r <= out_clamped_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_clamped = out_clamped_r;

endmodule

`default_nettype wire

// ----- rtl/core/slur_checker.sv -----
// slur_checker: port-level checks for the shuffled Lehmer generator, bound
// to the top level; depends on slur_pkg
`default_nettype none

module slur_checker
  import slur_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [VAL_W-1:0] out_sample,
  input wire logic             out_clamped
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("result changed while stalled");

  // the generator never yields zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample != '0)
    else $error("zero sample");

  a_clamp_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clamped == (out_sample >= CLAMP_LIMIT))
    else $error("clamp flag disagrees with sample");

  // one request at a time: busy right after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

endmodule

bind shuffled_lehmer_uniform_rng slur_checker u_slur_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_sample (out_sample),
  .out_clamped(out_clamped)
);

`default_nettype wire

// ----- test/shuffled_lehmer_uniform_rng_tb.sv -----
// shuffled_lehmer_uniform_rng_tb: self-checking bench for the shuffled lehmer generator
// drives draw and reseed requests, predicts each sample in-bench and compares it
// depends on slur_pkg and shuffled_lehmer_uniform_rng only

module shuffled_lehmer_uniform_rng_tb;
  import slur_pkg::*;

  localparam int unsigned ENTRIES       = DEF_TABLE_ENTRIES;
  localparam int unsigned RANDOM_REQS   = 1300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 2 * (ENTRIES + WARMUP_EXTRA) + 20;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam longint unsigned SLOT_SPAN = 64'd1 + (64'(LCG_MOD) - 64'd1) / 64'(ENTRIES);

  typedef struct packed {
    logic             command;
    logic [VAL_W-1:0] seed;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] sample;
    logic             clamped;
  } sample_t;

  // sender idle, receiver idle, in percent, per phase
  localparam int TX_IDLE_PCT [3] = '{20, 60, 0};
  localparam int RX_IDLE_PCT [3] = '{60, 20, 0};

  // no sample here is obvious by inspection, so every row goes through the predictor
  localparam int N_DIRECTED = 16;
  localparam request_t DIRECTED [N_DIRECTED] = '{
    '{CMD_DRAW,   31'd0},          // first draw after reset seeds, zero seed taken as one
    '{CMD_DRAW,   31'h7FFF_FFFF},  // seed ignored on a plain draw
    '{CMD_DRAW,   31'd12345},
    '{CMD_DRAW,   31'd0},
    '{CMD_RESEED, 31'h7FFF_FFFF},  // equals the modulus, folds to zero then one
    '{CMD_DRAW,   31'd0},
    '{CMD_RESEED, 31'd0},
    '{CMD_RESEED, 31'd1},
    '{CMD_RESEED, 31'd2147483646},
    '{CMD_DRAW,   31'd2147483646},
    '{CMD_DRAW,   31'd1},
    '{CMD_RESEED, 31'h2AAA_AAAA},
    '{CMD_RESEED, 31'h5555_5555},
    '{CMD_DRAW,   31'h5555_5555},
    '{CMD_DRAW,   31'd0},
    '{CMD_RESEED, 31'd16807}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_command;
  logic [VAL_W-1:0] in_seed;
  logic             out_valid;
  logic             out_ready;
  logic [VAL_W-1:0] out_sample;
  logic             out_clamped;

  shuffled_lehmer_uniform_rng dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_seed    (in_seed),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_clamped(out_clamped)
  );

  // predictor state
  logic [VAL_W-1:0] gen_state = 31'd1;
  logic [VAL_W-1:0] shuffle_out = '0;
  logic [VAL_W-1:0] shuffle_slots [ENTRIES];

  sample_t     expected_samples [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          idle_phase = 0;

  always #6 clk = ~clk;

  function automatic logic [VAL_W-1:0] lehmer_advance(input logic [VAL_W-1:0] x);
    longint unsigned prod;
    prod = 64'(x) * 64'(LCG_MULT);
    return VAL_W'(prod % 64'(LCG_MOD));
  endfunction

  function void predict_sample(input request_t req);
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] picked;
    longint unsigned  slot;
    if (req.command == CMD_RESEED || shuffle_out == '0) begin
      s = VAL_W'(64'(req.seed) % 64'(LCG_MOD));
      if (s == '0) s = 31'd1;
      // warm-up countdown, the last ENTRIES steps fill the table top down
      for (int unsigned n = ENTRIES + WARMUP_EXTRA; n > 0; n--) begin
        s = lehmer_advance(s);
        if (n - 1 < ENTRIES) shuffle_slots[n-1] = s;
      end
      gen_state   = s;
      shuffle_out = shuffle_slots[0];
    end
    gen_state = lehmer_advance(gen_state);
    slot = 64'(shuffle_out) / SLOT_SPAN;
    if (slot >= ENTRIES) slot = ENTRIES - 1;
    picked              = shuffle_slots[slot];
    shuffle_slots[slot] = gen_state;
    shuffle_out         = picked;
    expected_samples.push_back('{picked, picked >= CLAMP_LIMIT});
  endfunction

  function void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endfunction

  function automatic request_t random_request();
    request_t req;
    // mostly runs of draws, with a reseed now and then
    req.command = ($urandom_range(99) < 8) ? CMD_RESEED : CMD_DRAW;
    case ($urandom_range(15))
      0:       req.seed = '0;
      1:       req.seed = '1;
      2:       req.seed = LCG_MOD - 31'd1;
      default: req.seed = VAL_W'($urandom);
    endcase
    return req;
  endfunction

  task automatic send_request(input request_t req);
    while ($urandom_range(99) < TX_IDLE_PCT[idle_phase]) @(negedge clk);
    in_valid   = 1'b1;
    in_command = req.command;
    in_seed    = req.seed;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= RX_IDLE_PCT[idle_phase]);
  end

  always @(posedge clk) begin : monitor
    sample_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("shuffled_lehmer_uniform_rng_tb: done, errors");
      $finish;
    end else if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("unexpected sample %0d clamped %0b", out_sample, out_clamped));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want.sample)
            flag_mismatch($sformatf("sample: expected %0d, got %0d", want.sample, out_sample));
          if (out_clamped !== want.clamped)
            flag_mismatch($sformatf("clamped: expected %0b, got %0b (sample %0d)",
                                    want.clamped, out_clamped, want.sample));
        end
      end
      if (in_valid && in_ready) predict_sample('{in_command, in_seed});
    end
  end

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_DRAW;
    in_seed    = '0;
    out_ready  = 1'b0;
    foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_request(DIRECTED[i]);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      idle_phase = (i * 3) / RANDOM_REQS;
      send_request(random_request());
    end

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_samples.size() != 0)
      flag_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));

    if (mismatches == 0) begin
      $display("shuffled_lehmer_uniform_rng_tb: done, clean");
    end else begin
      $display("shuffled_lehmer_uniform_rng_tb: done, errors");
    end
    $finish;
  end

endmodule
